>>> rtl/mexp_pkg.sv
package mexp_pkg;

    // fixed widths of the stream fields
    localparam int unsigned FIELD_WIDTH = 32;
    localparam int unsigned S_TDATA_WIDTH = 2 * FIELD_WIDTH;
    localparam int unsigned M_TDATA_WIDTH = FIELD_WIDTH;
    localparam int unsigned M_TUSER_WIDTH = 1;

    // default operand width, at most FIELD_WIDTH
    localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

endpackage

>>> rtl/modular_exponentiation_core.sv
// modular exponentiation core: power_result = base ** exponent mod modulus
//
// channels
//   config: cfg_valid/cfg_ready/cfg_data writes the modulus; cfg_ready is always
//     high; the modulus must only be changed while the core is idle (not enforced)
//   input: s_tvalid/s_tready/s_tdata, one beat carries base and exponent
//   result: m_tvalid/m_tready/m_tdata/m_tuser, one beat per input beat,
//     m_tuser flags a zero modulus (result then 0)
// timing
//   one bit-serial modular multiplier does all the work, one multiplier bit
//   per cycle; the base is first reduced mod the modulus, then each exponent
//   bit up to the highest set one gives a multiply into the accumulator if
//   set, and a squaring of the base
//   a zero modulus skips the multiplies and goes straight to the done state;
//   one item is worked on at a time, and the next beat is taken only once the
//   result has loaded and the core is idle again
// reset and stall
//   aresetn (synchronous, active low) clears the modulus to 0 and empties the core
//   a finished result waits in the output register while m_tready is low;
//   the next item is accepted meanwhile but its result waits for the slot
module modular_exponentiation_core #(
    parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // modulus write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0]    cfg_data,
    // tdata: base_value [31:0], exponent_value [63:32]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mexp_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    // tdata: power_result [31:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mexp_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    // tuser: modulus_error [0]
    output logic [mexp_pkg::M_TUSER_WIDTH-1:0]  m_tuser
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
    localparam int unsigned FW = mexp_pkg::FIELD_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [FW-1:0]   modulus_reg, modulus_next;
    logic [W-1:0]    exp_reg, exp_next;
    logic [W-1:0]    base_reg, base_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic            err_reg, err_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    mplr_reg, mplr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]   m_tdata_reg, m_tdata_next;
    logic            m_tuser_reg, m_tuser_next;

    logic [W-1:0]    mod_w;
    logic [W-1:0]    one_mod;
    logic [W-1:0]    mcand;
    logic [W+1:0]    sum;
    logic [W+1:0]    mod_x1;
    logic [W+1:0]    mod_x2;
    logic [W+1:0]    red;
    logic [W-1:0]    unit_res;
    logic            unit_last;
    logic            out_free;

    assign mod_w     = modulus_reg[W-1:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    // 1 reduced mod m, used as multiplicand when the base is reduced
    assign one_mod = (mod_w == W'(1)) ? '0 : W'(1);

    // shared unit: interleaved modular multiply, msb of mplr first
    assign mcand  = (state_reg == ST_REDUCE) ? one_mod : base_reg;
    assign sum    = {1'b0, rem_reg, 1'b0} + (mplr_reg[W-1] ? {2'b00, mcand} : '0);
    assign mod_x1 = {2'b00, mod_w};
    assign mod_x2 = {1'b0, mod_w, 1'b0};
    always_comb begin
        if (sum >= mod_x2) begin
            red = sum - mod_x2;
        end else if (sum >= mod_x1) begin
            red = sum - mod_x1;
        end else begin
            red = sum;
        end
    end
    assign unit_res  = red[W-1:0];
    assign unit_last = (cnt_reg == '0);

    // sequencer and datapath next state
    always_comb begin
        state_next    = state_reg;
        modulus_next  = modulus_reg;
        exp_next      = exp_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        rem_next      = rem_reg;
        mplr_next     = mplr_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (cfg_valid && cfg_ready) begin
            modulus_next = cfg_data;
        end

        // output slot empties on a taken beat
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // unit step in every multiply state
        if (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR) begin
            rem_next  = unit_res;
            mplr_next = {mplr_reg[W-2:0], 1'b0};
            cnt_next  = cnt_reg - CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    exp_next  = s_tdata[FW +: W];
                    mplr_next = s_tdata[W-1:0];
                    rem_next  = '0;
                    cnt_next  = CW'(W - 1);
                    if (mod_w == '0) begin
                        err_next   = 1'b1;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        err_next   = 1'b0;
                        acc_next   = W'(1);
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (unit_last) begin
                    base_next  = unit_res;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                rem_next = '0;
                cnt_next = CW'(W - 1);
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else if (exp_reg[0]) begin
                    mplr_next  = acc_reg;
                    state_next = ST_MUL;
                end else begin
                    mplr_next  = base_reg;
                    state_next = ST_SQR;
                end
            end
            ST_MUL: begin
                if (unit_last) begin
                    acc_next   = unit_res;
                    rem_next   = '0;
                    mplr_next  = base_reg;
                    cnt_next   = CW'(W - 1);
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (unit_last) begin
                    base_next  = unit_res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = FW'(acc_reg);
                    m_tuser_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            modulus_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            modulus_reg  <= modulus_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        exp_reg     <= exp_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        rem_reg     <= rem_next;
        mplr_reg    <= mplr_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core still ready after taking a beat");

    a_error_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("modulus error with nonzero result");

    a_rem_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR)
        |-> rem_reg < mod_w)
        else $error("partial remainder not reduced");

    a_base_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> base_reg < mod_w)
        else $error("running base not reduced");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside done state");

endmodule

>>> tb/tb_top.sv
module tb_top;

    localparam int unsigned FIELD_WIDTH = mexp_pkg::FIELD_WIDTH;
    localparam int unsigned S_TDATA_WIDTH = mexp_pkg::S_TDATA_WIDTH;
    localparam int unsigned M_TDATA_WIDTH = mexp_pkg::M_TDATA_WIDTH;
    localparam int unsigned M_TUSER_WIDTH = mexp_pkg::M_TUSER_WIDTH;

    // no-handshake cycles before the run is declared hung
    localparam int unsigned HANG_LIMIT = 20000;
    localparam int unsigned RX_HOLD_CYCLES = 800;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] power;
        logic                   err;
    } power_rec_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [FIELD_WIDTH-1:0]    cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;
    logic [M_TUSER_WIDTH-1:0]  m_tuser;

    // modulus as last written, used by the predictor
    logic [FIELD_WIDTH-1:0]    cur_modulus = '0;
    power_rec_t                power_expected[$];
    int unsigned               fail_count = 0;

    // idling controls
    bit                        tx_idle_on = 1'b1;
    bit                        rx_idle_on = 1'b1;
    int unsigned               rx_wait = 0;
    int unsigned               rx_hold_req = 0;
    logic                      rx_hold = 1'b0;
    int unsigned               quiet_cycles = 0;

    modular_exponentiation_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // right-to-left square and multiply, 64-bit products
    function automatic power_rec_t expected_power(logic [FIELD_WIDTH-1:0] b,
                                                  logic [FIELD_WIDTH-1:0] e,
                                                  logic [FIELD_WIDTH-1:0] m);
        power_rec_t             rec;
        bit [63:0]              acc;
        bit [63:0]              run;
        bit [63:0]              mod64;
        logic [FIELD_WIDTH-1:0] ex;
        if (m == '0) begin
            rec.power = '0;
            rec.err = 1'b1;
            return rec;
        end
        mod64 = {32'd0, m};
        acc = 64'd1;
        run = {32'd0, b} % mod64;
        ex = e;
        while (ex != '0) begin
            if (ex[0]) begin
                acc = (acc * run) % mod64;
            end
            ex = ex >> 1;
            run = (run * run) % mod64;
        end
        rec.power = acc[FIELD_WIDTH-1:0];
        rec.err = 1'b0;
        return rec;
    endfunction

    // mostly short exponents to keep the run short, some full width and zero
    function automatic logic [FIELD_WIDTH-1:0] draw_exponent();
        int unsigned pick;
        int unsigned nbits;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return '0;
        end
        if (pick <= 2) begin
            return $urandom;
        end
        nbits = $urandom_range(1, 10);
        return $urandom & ((32'd1 << nbits) - 32'd1);
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] draw_base(logic [FIELD_WIDTH-1:0] m);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                return $urandom_range(0, 3);
            end
            1: begin
                return m - 32'd1;
            end
            2: begin
                return m + $urandom_range(0, 3);
            end
            3: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // one operand beat; expectation is queued at the accepting edge
    task automatic send_operands(logic [FIELD_WIDTH-1:0] base_value,
                                 logic [FIELD_WIDTH-1:0] exponent_value);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {exponent_value, base_value};
        do @(posedge aclk); while (!s_tready);
        power_expected.push_back(expected_power(base_value, exponent_value, cur_modulus));
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_input();
        while (power_expected.size() != 0) @(posedge aclk);
    endtask

    // modulus is only changed with the core empty
    task automatic write_modulus(logic [FIELD_WIDTH-1:0] value);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_modulus = value;
    endtask

    task automatic test_zero_modulus();
        write_modulus(32'd0);
        send_operands(32'd5, 32'd3);
        send_operands(32'd0, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        // modulus of one: zero exponent gives 1 unreduced, otherwise 0
        write_modulus(32'd1);
        send_operands(32'd7, 32'd0);
        send_operands(32'd7, 32'd5);
        send_operands(32'd0, 32'd0);
        // largest modulus with field extremes
        write_modulus(32'hFFFF_FFFF);
        send_operands(32'd0, 32'd0);
        send_operands(32'd0, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1);
        send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_operands(32'd2, 32'd31);
        send_operands(32'd2, 32'd32);
        send_operands(32'h1234_5678, 32'hFFFF_FFFF);
        write_modulus(32'd2);
        send_operands(32'd3, 32'hFFFF_FFFF);
        send_operands(32'd4, 32'd1);
        // prime modulus, bases just below and above the modulus
        write_modulus(32'hFFFF_FFFB);
        send_operands(32'hFFFF_FFFA, 32'd2);
        send_operands(32'hFFFF_FFFE, 32'd3);
        write_modulus(32'h8000_0000);
        send_operands(32'd3, 32'h8000_0000);
        send_operands(32'h8000_0001, 32'd7);
    endtask

    task automatic run_random_phase(logic [FIELD_WIDTH-1:0] m, int unsigned count);
        write_modulus(m);
        repeat (count) begin
            send_operands(draw_base(m), draw_exponent());
        end
    endtask

    task automatic test_random();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random_phase($urandom | 32'h8000_0000, 30);
        run_random_phase($urandom_range(2, 1000), 30);
        run_random_phase(32'hFFFF_FFFF, 30);
        // stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_phase($urandom, 30);
        run_random_phase(32'd0, 20);
        tx_idle_on = 1'b1;
        run_random_phase($urandom_range(2, 65535), 30);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b0;
        run_random_phase(32'd1, 20);
        tx_idle_on = 1'b1;
        run_random_phase($urandom, 30);
        run_random_phase(32'h7FFF_FFFF, 20);
    endtask

    // receiver holds off while short items keep coming, so the core backs up
    task automatic test_backpressure();
        write_modulus($urandom | 32'h1);
        tx_idle_on = 1'b0;
        rx_hold_req = RX_HOLD_CYCLES;
        repeat (12) begin
            send_operands($urandom, $urandom_range(1, 7));
        end
        tx_idle_on = 1'b1;
    endtask

    // sender stops until every result is back, a few times over
    task automatic test_drain_pause();
        write_modulus($urandom_range(3, 1 << 20));
        repeat (4) begin
            repeat (4) begin
                send_operands($urandom, draw_exponent());
            end
            wait_drained();
        end
    endtask

    // long receiver hold-off, counted here
    initial begin
        forever begin
            wait (rx_hold_req != 0);
            @(posedge aclk);
            rx_hold <= 1'b1;
            repeat (rx_hold_req) @(posedge aclk);
            rx_hold <= 1'b0;
            rx_hold_req = 0;
        end
    end

    // result receiver and checker
    always @(posedge aclk) begin
        power_rec_t exp_rec;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (power_expected.size() == 0) begin
                    $error("unexpected result beat power_result %0h modulus_error %0h",
                           m_tdata, m_tuser[0]);
                    fail_count++;
                end else begin
                    exp_rec = power_expected.pop_front();
                    if (m_tdata !== exp_rec.power) begin
                        $error("power_result expected %0h actual %0h", exp_rec.power, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_rec.err) begin
                        $error("modulus_error expected %0h actual %0h", exp_rec.err, m_tuser[0]);
                        fail_count++;
                    end
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 8) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // hang watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("modular_exponentiation_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_modulus();
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("modular_exponentiation_core: match");
        end else begin
            $display("modular_exponentiation_core: mismatch");
        end
        $finish;
    end

endmodule
